// ----- rtl/dpc_pkg.sv -----
// Package for the differential pump controller: payload types, register map,
// action codes and temperature limits. No dependencies.
package dpc_pkg;

  localparam int unsigned TEMP_W     = 12;
  localparam int unsigned RUN_W      = 22;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 22;

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic signed [TEMP_W:0]   wide_t;
  typedef logic [RUN_W-1:0]         run_t;

  localparam temp_t T_VALID_LO  = -12'sd160;
  localparam temp_t T_VALID_HI  = 12'sd1440;
  localparam temp_t T_ACCEPT_LO = -12'sd880;
  localparam temp_t T_ACCEPT_HI = 12'sd2000;
  localparam run_t  RUN_MAX     = {RUN_W{1'b1}};

  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_BASEMENT = 2'd1,
    ACT_ROOF     = 2'd2
  } act_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELTA_ON   = 3'd0,
    CFG_DELTA_OFF  = 3'd1,
    CFG_MIN_SOLAR  = 3'd2,
    CFG_MAX_BUFFER = 3'd3,
    CFG_MAX_RUN    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] delta_on;
    logic [7:0] delta_off;
    logic [9:0] min_solar;
    logic [9:0] max_buffer;
    run_t       max_run_ms;
  } cfg_t;

  typedef struct packed {
    temp_t basement;
    logic  basement_present;
    temp_t roof;
    logic  roof_present;
    logic  running;
    run_t  run_elapsed;
    logic  fault;
  } ctl_state_t;

  typedef struct packed {
    logic pump_on;
    logic fault;
    logic basement_ok;
    logic roof_ok;
  } result_t;

endpackage

// ----- rtl/dpc_if.sv -----
// Request and result channel interfaces for the differential pump controller.
// Depends on nothing.
interface dpc_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic signed [11:0] sample_temp;
  logic              sample_missing;

  modport source(output valid, action, sample_temp, sample_missing, input ready);
  modport sink(input valid, action, sample_temp, sample_missing, output ready);
endinterface

interface dpc_res_if;
  logic valid;
  logic ready;
  logic pump_on;
  logic fault;
  logic basement_ok;
  logic roof_ok;

  modport source(output valid, pump_on, fault, basement_ok, roof_ok, input ready);
  modport sink(input valid, pump_on, fault, basement_ok, roof_ok, output ready);
endinterface

// ----- rtl/dpc_eval.sv -----
// Next-state and result logic for one request of the pump controller.
// Depends on dpc_pkg.
module dpc_eval #(
  parameter int unsigned FRESH_MS = 60000,
  parameter int unsigned AgeW     = $clog2(FRESH_MS + 1)
) (
  input  dpc_pkg::cfg_t       cfg_i,
  input  logic [1:0]          action_i,
  input  dpc_pkg::temp_t      temp_i,
  input  logic                missing_i,
  input  dpc_pkg::ctl_state_t st_i,
  input  logic [AgeW-1:0]     bage_i,
  input  logic [AgeW-1:0]     rage_i,
  output dpc_pkg::ctl_state_t st_o,
  output logic [AgeW-1:0]     bage_o,
  output logic [AgeW-1:0]     rage_o,
  output dpc_pkg::result_t    res_o
);
  import dpc_pkg::*;

  localparam logic [AgeW-1:0] FreshA = AgeW'(FRESH_MS);

  ctl_state_t      st_a;
  ctl_state_t      st_n;
  logic [AgeW-1:0] bage_a;
  logic [AgeW-1:0] rage_a;
  logic            b_ok;
  logic            r_ok;
  wide_t           diff;
  wide_t           bas_w;
  wide_t           roof_w;
  logic            stop;
  logic            start;

  always_comb begin
    st_a   = st_i;
    bage_a = bage_i;
    rage_a = rage_i;
    case (act_e'(action_i))
      ACT_TICK: begin
        bage_a = (bage_i < FreshA) ? bage_i + AgeW'(1) : FreshA;
        rage_a = (rage_i < FreshA) ? rage_i + AgeW'(1) : FreshA;
        if (st_i.running && st_i.run_elapsed != RUN_MAX) begin
          st_a.run_elapsed = st_i.run_elapsed + run_t'(1);
        end
      end
      ACT_BASEMENT: begin
        if (!missing_i && temp_i > T_ACCEPT_LO && temp_i < T_ACCEPT_HI) begin
          st_a.basement         = temp_i;
          st_a.basement_present = 1'b1;
          bage_a                = '0;
        end
      end
      ACT_ROOF: begin
        st_a.roof         = temp_i;
        st_a.roof_present = !missing_i;
        rage_a            = '0;
      end
      default: ;
    endcase
  end

  assign b_ok = st_a.basement_present && st_a.basement > T_VALID_LO &&
                st_a.basement < T_VALID_HI && bage_a < FreshA;
  assign r_ok = st_a.roof_present && st_a.roof > T_VALID_LO &&
                st_a.roof < T_VALID_HI && rage_a < FreshA;

  assign bas_w  = {st_a.basement[TEMP_W-1], st_a.basement};
  assign roof_w = {st_a.roof[TEMP_W-1], st_a.roof};
  assign diff   = roof_w - bas_w;

  assign stop  = diff < $signed({5'b00000, cfg_i.delta_off}) ||
                 bas_w >= $signed({3'b000, cfg_i.max_buffer}) ||
                 roof_w < $signed({3'b000, cfg_i.min_solar});
  assign start = diff >= $signed({5'b00000, cfg_i.delta_on}) &&
                 bas_w < $signed({3'b000, cfg_i.max_buffer}) &&
                 roof_w >= $signed({3'b000, cfg_i.min_solar});

  always_comb begin
    st_n = st_a;
    if (act_e'(action_i) == ACT_TICK && !st_a.fault) begin
      if (!b_ok || !r_ok) begin
        st_n.running = 1'b0;
      end else if (st_a.running && st_a.run_elapsed > cfg_i.max_run_ms) begin
        st_n.fault   = 1'b1;
        st_n.running = 1'b0;
      end else if (st_a.running) begin
        if (stop) begin
          st_n.running = 1'b0;
        end
      end else if (start) begin
        st_n.running     = 1'b1;
        st_n.run_elapsed = '0;
      end
    end
  end

  assign st_o   = st_n;
  assign bage_o = bage_a;
  assign rage_o = rage_a;
  assign res_o  = '{pump_on: st_n.running, fault: st_n.fault,
                    basement_ok: b_ok, roof_ok: r_ok};

endmodule

// ----- rtl/differential_pump_controller_core.sv -----
// Channel     | Dir | Fields
// req_i       | in  | action, sample_temp, sample_missing
// res_o       | out | pump_on, fault, basement_ok, roof_ok
// cfg_*_i     | in  | write enable, register index, data
//
// One request per cycle while res_o.ready takes the results; a request goes
// through the input register, then the update logic, into the result register.
// Reset is async active low; valid, state and config registers get defaults.
// req_i.ready drops only while the input register is full and the result
// register holds a result that res_o.ready does not take.
// Top level of the differential pump controller. Depends on dpc_pkg,
// dpc_if and dpc_eval.
module differential_pump_controller_core #(
  parameter int unsigned FRESH_MS = 60000
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dpc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dpc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  dpc_req_if.sink                          req_i,
  dpc_res_if.source                        res_o
);
  import dpc_pkg::*;

  localparam int unsigned AgeW = $clog2(FRESH_MS + 1);

  cfg_t            cfg_q;
  logic            in_vld_q;
  logic [1:0]      in_act_q;
  temp_t           in_temp_q;
  logic            in_miss_q;
  ctl_state_t      st_q;
  ctl_state_t      st_d;
  logic [AgeW-1:0] bage_q;
  logic [AgeW-1:0] bage_d;
  logic [AgeW-1:0] rage_q;
  logic [AgeW-1:0] rage_d;
  logic            out_vld_q;
  result_t         res_q;
  result_t         res_d;
  logic            adv;
  logic            fire;
  logic            take;

  assign adv         = !out_vld_q || res_o.ready;
  assign fire        = in_vld_q && adv;
  assign req_i.ready = !in_vld_q || adv;
  assign take        = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{delta_on: 8'd80, delta_off: 8'd48, min_solar: 10'd480,
                 max_buffer: 10'd880, max_run_ms: 22'd3600000};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DELTA_ON:   cfg_q.delta_on   <= cfg_data_i[7:0];
        CFG_DELTA_OFF:  cfg_q.delta_off  <= cfg_data_i[7:0];
        CFG_MIN_SOLAR:  cfg_q.min_solar  <= cfg_data_i[9:0];
        CFG_MAX_BUFFER: cfg_q.max_buffer <= cfg_data_i[9:0];
        CFG_MAX_RUN:    cfg_q.max_run_ms <= cfg_data_i[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (take) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_act_q  <= req_i.action;
      in_temp_q <= req_i.sample_temp;
      in_miss_q <= req_i.sample_missing;
    end
  end

  dpc_eval #(
    .FRESH_MS (FRESH_MS),
    .AgeW     (AgeW)
  ) u_eval (
    .cfg_i     (cfg_q),
    .action_i  (in_act_q),
    .temp_i    (in_temp_q),
    .missing_i (in_miss_q),
    .st_i      (st_q),
    .bage_i    (bage_q),
    .rage_i    (rage_q),
    .st_o      (st_d),
    .bage_o    (bage_d),
    .rage_o    (rage_d),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= '0;
      bage_q <= '0;
      rage_q <= '0;
    end else if (fire) begin
      st_q   <= st_d;
      bage_q <= bage_d;
      rage_q <= rage_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.pump_on     = res_q.pump_on;
  assign res_o.fault       = res_q.fault;
  assign res_o.basement_ok = res_q.basement_ok;
  assign res_o.roof_ok     = res_q.roof_ok;

endmodule

// ----- rtl/dpc_checker.sv -----
// Port-level checks for the differential pump controller result channel,
// bound to differential_pump_controller_core. Depends on nothing.
module dpc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic valid_i,
  input logic ready_i,
  input logic pump_on_i,
  input logic fault_i,
  input logic basement_ok_i,
  input logic roof_ok_i
);

  logic fault_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_seen_q <= 1'b0;
    end else if (valid_i && ready_i && fault_i) begin
      fault_seen_q <= 1'b1;
    end
  end

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !valid_i)
    else $error("result valid during reset");

  a_fault_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && fault_seen_q |-> fault_i)
    else $error("latched fault cleared without reset");

  a_fault_stops_pump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && fault_i |-> !pump_on_i)
    else $error("pump running with fault latched");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=>
      valid_i && $stable({pump_on_i, fault_i, basement_ok_i, roof_ok_i}))
    else $error("stalled result changed");

endmodule

bind differential_pump_controller_core dpc_checker u_dpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .valid_i       (res_o.valid),
  .ready_i       (res_o.ready),
  .pump_on_i     (res_o.pump_on),
  .fault_i       (res_o.fault),
  .basement_ok_i (res_o.basement_ok),
  .roof_ok_i     (res_o.roof_ok)
);
